// ===== sv/hbc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package hbc_pkg;
	localparam int MaxEntries = 256;
	localparam int MaxBuckets = 32;
	localparam int BlockBits = 32;

	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_FLUSH = 2'd2;

	localparam logic [0:0] REG_BUCKETS = 1'd0;
	localparam logic [0:0] REG_LIMIT   = 1'd1;

	typedef struct packed {
		logic       hit;
		logic [7:0] slot;
		logic       fetch_request;
		logic       writeback_valid;
		logic [31:0] writeback_block;
		logic [7:0] writeback_slot;
		logic       status;
	} result_t;

	// request from sequencer to the modulo unit
	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctl_t;
endpackage
`default_nettype wire

// ===== sv/hbc_stream_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface hbc_stream_if #(parameter int W = 1) (input wire logic clk);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/hashed_block_cache_tag_manager_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A read/write miss hashes the block, walks its whole bucket chain and then allocates a slot;
// a hit ends the walk at the match. With no free slot, an eviction scans every bucket for the
// fullest and drops its head; a dirty victim is also unlinked from the dirty list and written back.
// Flush writes back the dirty-list tail, or sets status when nothing is dirty; an unused opcode just returns.
// Throughput: one item at a time; in.ready is low from transfer until the result leaves.
// Reset clears dirty bits, bucket populations, dirty list and use count at once.
module hashed_block_cache_tag_manager_top #(
	parameter int MAX_ENTRIES = hbc_pkg::MaxEntries,
	parameter int MAX_BUCKETS = hbc_pkg::MaxBuckets,
	parameter int BLOCK_BITS = hbc_pkg::BlockBits
) (
	input  wire logic clk,
	input  wire logic arst_n,
	hbc_stream_if.sink in_ch,
	hbc_stream_if.source out_ch,
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [2:0] paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import hbc_pkg::*;

	localparam int SW = $clog2(MAX_ENTRIES);
	localparam int BKW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int DW = $clog2(MAX_BUCKETS + 1);

	localparam logic [4:0] S_IDLE = 5'd0, S_HASH = 5'd1, S_LK0 = 5'd2, S_LK1 = 5'd3,
		S_LK2 = 5'd4, S_SCAN = 5'd5, S_EV0 = 5'd6, S_EV1 = 5'd7, S_EV2 = 5'd8,
		S_DR0 = 5'd9, S_DR1 = 5'd10, S_DR2 = 5'd11, S_INS = 5'd12, S_MARK = 5'd13,
		S_OUT = 5'd14, S_FL0 = 5'd15, S_FL1 = 5'd16, S_ALLOC = 5'd17, S_DR3 = 5'd18;

	logic [5:0] bcount_q;
	logic [8:0] elimit_q;
	logic [4:0] st_q;
	logic [1:0] op_q;
	logic [BLOCK_BITS-1:0] blk_q;
	logic [BKW-1:0] b_q;
	logic [SW-1:0] s_q, walk_q, ev_q;
	logic [CW-1:0] used_q, left_q, best_n_q;
	logic [BKW-1:0] best_q;
	logic [DW-1:0] scan_q;
	logic [MAX_ENTRIES-1:0] dirty_q;
	logic [CW-1:0] pop_q [MAX_BUCKETS];
	logic [SW-1:0] head_q [MAX_BUCKETS];
	logic [SW-1:0] tail_q [MAX_BUCKETS];
	logic [SW-1:0] dl_head_q, dl_tail_q;
	logic dl_any_q;
	logic [SW-1:0] rm_q;
	logic rm_prev_q;
	result_t res_q;
	logic out_v_q;

	// effective config
	logic [DW-1:0] eff_b;
	logic [CW-1:0] eff_l;
	always_comb begin
		eff_b = (bcount_q == 6'd0 || 32'(bcount_q) > MAX_BUCKETS) ? DW'(MAX_BUCKETS)
			: DW'(bcount_q);
		eff_l = (elimit_q == 9'd0 || 32'(elimit_q) > MAX_ENTRIES) ? CW'(MAX_ENTRIES)
			: CW'(elimit_q);
	end

	// APB
	logic wr_en;
	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;
	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_LIMIT) prdata = 32'(elimit_q);
		else prdata = 32'(bcount_q);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcount_q <= 6'd32;
			elimit_q <= 9'd256;
		end else if (wr_en && paddr[1:0] == 2'b00) begin
			if (paddr[2] == REG_BUCKETS) bcount_q <= pwdata[5:0];
			else elimit_q <= pwdata[8:0];
		end
	end

	logic in_xfer, out_xfer;
	logic [1:0] in_op;
	logic [BLOCK_BITS-1:0] in_blk;
	assign in_op = in_ch.data[BLOCK_BITS+1:BLOCK_BITS];
	assign in_blk = in_ch.data[BLOCK_BITS-1:0];

	// modulo unit
	logic mod_start, mod_done;
	logic [DW-1:0] mod_rem;
	hbc_mod #(.BLOCK_BITS(BLOCK_BITS), .BW(DW)) u_mod (
		.clk(clk), .arst_n(arst_n), .start(mod_start), .dividend(in_blk),
		.divisor(eff_b), .done(mod_done), .rem(mod_rem)
	);

	// RAMs: tag, bucket next, dirty prev, dirty next
	logic tag_we, bn_we, dp_we, dn_we;
	logic [SW-1:0] tag_wa, bn_wa, dp_wa, dn_wa, tag_ra, bn_ra, dp_ra, dn_ra;
	logic [BLOCK_BITS-1:0] tag_rd;
	logic [SW-1:0] bn_wd, dp_wd, dn_wd, bn_rd, dp_rd, dn_rd;
	hbc_ram #(.WIDTH(BLOCK_BITS), .DEPTH(MAX_ENTRIES)) u_tag (.clk(clk), .we(tag_we),
		.waddr(tag_wa), .wdata(blk_q), .raddr(tag_ra), .rdata(tag_rd));
	hbc_ram #(.WIDTH(SW), .DEPTH(MAX_ENTRIES)) u_bn (.clk(clk), .we(bn_we),
		.waddr(bn_wa), .wdata(bn_wd), .raddr(bn_ra), .rdata(bn_rd));
	hbc_ram #(.WIDTH(SW), .DEPTH(MAX_ENTRIES)) u_dp (.clk(clk), .we(dp_we),
		.waddr(dp_wa), .wdata(dp_wd), .raddr(dp_ra), .rdata(dp_rd));
	hbc_ram #(.WIDTH(SW), .DEPTH(MAX_ENTRIES)) u_dn (.clk(clk), .we(dn_we),
		.waddr(dn_wa), .wdata(dn_wd), .raddr(dn_ra), .rdata(dn_rd));

	assign in_ch.ready = (st_q == S_IDLE) && !out_v_q;
	assign in_xfer = in_ch.valid && in_ch.ready;
	assign out_xfer = out_ch.valid && out_ch.ready;
	assign out_ch.valid = out_v_q;
	assign out_ch.data = res_q;

	assign mod_start = in_xfer && (in_op == OP_READ || in_op == OP_WRITE);

	// combinational RAM controls per state
	always_comb begin
		tag_we = 1'b0; bn_we = 1'b0; dp_we = 1'b0; dn_we = 1'b0;
		tag_wa = s_q; bn_wa = tail_q[b_q]; dp_wa = s_q; dn_wa = dl_tail_q;
		bn_wd = s_q; dp_wd = dl_tail_q; dn_wd = s_q;
		tag_ra = walk_q; bn_ra = walk_q; dp_ra = rm_q; dn_ra = rm_q;
		case (st_q)
			S_EV0: bn_ra = ev_q;
			S_DR3: begin
				// unlink middle element
				dn_we = 1'b1; dn_wa = dp_rd; dn_wd = dn_rd;
				dp_we = 1'b1; dp_wa = dn_rd; dp_wd = dp_rd;
			end
			S_INS: begin
				tag_we = 1'b1;
				bn_we = (pop_q[b_q] != '0);
			end
			S_MARK: if (op_q == OP_WRITE && !dirty_q[s_q] && dl_any_q) begin
				dn_we = 1'b1; dp_we = 1'b1;
			end
			S_FL0: tag_ra = dl_tail_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			out_v_q <= 1'b0;
			used_q <= '0;
			dirty_q <= '0;
			dl_any_q <= 1'b0;
			for (int i = 0; i < MAX_BUCKETS; i++) pop_q[i] <= '0;
		end else begin
			if (out_xfer) out_v_q <= 1'b0;
			case (st_q)
				S_IDLE: if (in_xfer) begin
					op_q <= in_op;
					blk_q <= in_blk;
					res_q <= '0;
					if (in_op == OP_READ || in_op == OP_WRITE) st_q <= S_HASH;
					else if (in_op == OP_FLUSH) st_q <= S_FL0;
					else st_q <= S_OUT;
				end
				S_HASH: if (mod_done) begin
					b_q <= BKW'(mod_rem);
					walk_q <= head_q[BKW'(mod_rem)];
					left_q <= pop_q[BKW'(mod_rem)];
					st_q <= S_LK0;
				end
				S_LK0: st_q <= (left_q == '0) ? S_ALLOC : S_LK1;
				S_LK1: st_q <= S_LK2; // read data settles
				S_LK2: begin
					if (tag_rd == blk_q) begin
						res_q.hit <= 1'b1;
						s_q <= walk_q;
						st_q <= S_MARK;
					end else begin
						walk_q <= bn_rd;
						left_q <= left_q - 1'b1;
						st_q <= S_LK0;
					end
				end
				S_ALLOC: begin
					if (op_q == OP_READ) res_q.fetch_request <= 1'b1;
					if (used_q < eff_l) begin
						s_q <= SW'(used_q);
						used_q <= used_q + 1'b1;
						st_q <= S_INS;
					end else begin
						scan_q <= '0;
						best_q <= '0;
						best_n_q <= '0;
						st_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (pop_q[BKW'(scan_q)] > best_n_q) begin
						best_n_q <= pop_q[BKW'(scan_q)];
						best_q <= BKW'(scan_q);
					end
					scan_q <= scan_q + 1'b1;
					if (scan_q == DW'(MAX_BUCKETS - 1)) st_q <= S_EV0;
					ev_q <= head_q[best_q];
				end
				S_EV0: begin
					ev_q <= head_q[best_q];
					walk_q <= head_q[best_q];
					st_q <= S_EV1;
				end
				S_EV1: st_q <= S_EV2;
				S_EV2: begin
					head_q[best_q] <= bn_rd;
					pop_q[best_q] <= pop_q[best_q] - 1'b1;
					s_q <= ev_q;
					if (dirty_q[ev_q]) begin
						res_q.writeback_valid <= 1'b1;
						res_q.writeback_block <= 32'(tag_rd);
						res_q.writeback_slot <= 8'(ev_q);
						rm_q <= ev_q;
						rm_prev_q <= 1'b0;
						st_q <= S_DR0;
					end else st_q <= S_INS;
				end
				S_DR0: st_q <= S_DR1;
				S_DR1: begin
					dirty_q[rm_q] <= 1'b0;
					if (rm_q == dl_head_q && rm_q == dl_tail_q) dl_any_q <= 1'b0;
					else if (rm_q == dl_head_q) dl_head_q <= dn_rd;
					else if (rm_q == dl_tail_q) dl_tail_q <= dp_rd;
					st_q <= (rm_q != dl_head_q && rm_q != dl_tail_q) ? S_DR3 : S_DR2;
				end
				S_DR3: st_q <= S_DR2;
				S_DR2: st_q <= rm_prev_q ? S_OUT : S_INS;
				S_INS: begin
					dirty_q[s_q] <= 1'b0;
					if (pop_q[b_q] == '0) head_q[b_q] <= s_q;
					tail_q[b_q] <= s_q;
					pop_q[b_q] <= pop_q[b_q] + 1'b1;
					st_q <= S_MARK;
				end
				S_MARK: begin
					res_q.slot <= 8'(s_q);
					if (op_q == OP_WRITE && !dirty_q[s_q]) begin
						dirty_q[s_q] <= 1'b1;
						if (!dl_any_q) begin
							dl_head_q <= s_q;
							dl_any_q <= 1'b1;
						end
						dl_tail_q <= s_q;
					end
					st_q <= S_OUT;
				end
				S_FL0: begin
					if (dl_any_q) begin
						rm_q <= dl_tail_q;
						rm_prev_q <= 1'b1;
						st_q <= S_FL1;
					end else begin
						res_q.status <= 1'b1;
						st_q <= S_OUT;
					end
				end
				S_FL1: begin
					res_q.writeback_valid <= 1'b1;
					res_q.writeback_block <= 32'(tag_rd);
					res_q.writeback_slot <= 8'(rm_q);
					st_q <= S_DR1;
				end
				S_OUT: begin
					out_v_q <= 1'b1;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// tag read for eviction needs ev address; tag_ra follows walk_q set in S_EV0

	a_busy_no_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != S_IDLE) |-> !in_ch.ready) else $error("ready while busy");
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CW'(MAX_ENTRIES)) else $error("use count overflow");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !out_ch.ready) |=> out_v_q) else $error("result dropped");
	a_wb_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && res_q.status) |-> !res_q.writeback_valid) else $error("bad flush");
endmodule
`default_nettype wire

// ===== sv/hbc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== sv/hbc_mod.sv =====
`timescale 1ns / 1ps
`default_nettype none
// restoring remainder, one bit per cycle
module hbc_mod #(
	parameter int BLOCK_BITS = 32,
	parameter int BW = 6
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [BLOCK_BITS-1:0] dividend,
	input  wire logic [BW-1:0]         divisor,
	output logic                       done,
	output logic      [BW-1:0]         rem
);
	localparam int CW = $clog2(BLOCK_BITS + 1);
	logic [BLOCK_BITS-1:0] sh_q;
	logic [BW-1:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic [BW:0] trial;
	assign trial = {rem_q, sh_q[BLOCK_BITS-1]};
	assign rem = rem_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(BLOCK_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
	always_ff @(posedge clk) begin
		if (start) begin
			sh_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			sh_q <= sh_q << 1;
			rem_q <= (trial >= {1'b0, divisor}) ? BW'(trial - {1'b0, divisor}) : BW'(trial);
		end
	end
endmodule
`default_nettype wire
